@@ sv/gau_pkg.sv @@
// ----------------------------------------------------------------------------
// gau_pkg
// Shared types and constants for the gravity acceleration update unit.
// ----------------------------------------------------------------------------
package gau_pkg;

    localparam int GM_W      = 48;
    localparam int ACC_W     = 64;
    localparam int QUO_W     = 64;
    localparam int MUL_CHUNK = 32;

    localparam logic [GM_W-1:0] GM_RESET = 48'd132712440018;

    typedef enum logic [1:0] {
        ST_APPLIED     = 2'd0,
        ST_INSENSITIVE = 2'd1,
        ST_ZERO_DIST   = 2'd2,
        ST_SATURATED   = 2'd3
    } status_t;

endpackage

@@ sv/gravity_acceleration_update_unit.sv @@
// ----------------------------------------------------------------------------
// gravity_acceleration_update_unit
// Adds the point-mass pull GM * d / |d|^3 of a source body to a target's
// acceleration, with bypass for insensitive targets and zero distance.
// The pipeline depth is set by the square root and the 64-stage dividers.
// Throughput: one item per cycle while the result side is not stalled.
// Reset: valid bits clear, gm register returns to the solar value.
// ----------------------------------------------------------------------------
module gravity_acceleration_update_unit
    import gau_pkg::*;
#(
    parameter int POS_BITS      = 48,
    parameter int ACC_FRAC_BITS = 48
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [GM_W-1:0]      cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // src_x, src_y, src_z, tgt_x, tgt_y, tgt_z, acc_x_in, acc_y_in, acc_z_in
    input  logic [((6*POS_BITS+3*ACC_W+7)/8)*8-1:0] s_tdata,
    // tgt_sensitive
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // acc_x_out, acc_y_out, acc_z_out
    output logic [3*ACC_W-1:0]   m_tdata,
    // status
    output logic [1:0]           m_tuser
);

    localparam int DW   = POS_BITS + 1;
    localparam int D2W  = 2 * DW + 2;
    localparam int RW   = D2W / 2;
    localparam int DENW = D2W + RW;
    localparam int PW   = GM_W + DW;
    localparam int NUMW = PW + ACC_FRAC_BITS;
    localparam int SIDW = 3 * ACC_W + 5;
    localparam int SIDN = RW + 69;
    localparam int NUMN = RW + 3;

    logic                en;
    logic [GM_W-1:0]     gm_reg;

    logic                v1_reg;
    logic [DW-1:0]       mag_reg [3];
    logic [SIDW-1:0]     side_reg;
    logic [DW-1:0]       diff [3];
    logic [2:0]          neg;

    logic [2*DW-1:0]     sq [3];
    logic [PW-1:0]       pr [3];
    logic [D2W-1:0]      d2_reg;
    logic [D2W-1:0]      d2_dly;
    logic [RW-1:0]       root;
    logic [DENW-1:0]     den;
    logic [PW-1:0]       pr_dly [3];
    logic [QUO_W-1:0]    quo [3];
    logic                v_end;
    logic [SIDW-1:0]     side_end;

    logic [ACC_W-1:0]    acc_in [3];
    logic [ACC_W-1:0]    acc_next [3];
    status_t             status_next;
    logic                sat;
    logic [ACC_W-1:0]    sum;

    logic                m_valid_reg;
    logic [3*ACC_W-1:0]  m_data_reg;
    status_t             m_status_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gm_reg <= GM_RESET;
        end else if (cfg_we) begin
            gm_reg <= cfg_wdata;
        end
    end

    // differences and magnitudes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = {s_tdata[i*POS_BITS + POS_BITS-1], s_tdata[i*POS_BITS +: POS_BITS]}
                    - {s_tdata[(i+3)*POS_BITS + POS_BITS-1],
                       s_tdata[(i+3)*POS_BITS +: POS_BITS]};
            neg[i]  = diff[i][DW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= neg[i] ? DW'(-diff[i]) : diff[i];
            end
            side_reg <= {s_tdata[6*POS_BITS +: 3*ACC_W], neg, s_tuser,
                         (diff[0] == '0) && (diff[1] == '0) && (diff[2] == '0)};
        end
    end

    generate
        for (genvar i = 0; i < 3; i++) begin : g_lane
            gau_mul #(.WA(DW), .WB(DW)) u_sq (
                .aclk (aclk), .en (en), .a (mag_reg[i]), .b (mag_reg[i]), .p (sq[i])
            );
            gau_mul #(.WA(GM_W), .WB(DW)) u_num (
                .aclk (aclk), .en (en), .a (gm_reg), .b (mag_reg[i]), .p (pr[i])
            );
            gau_dly #(.W(PW), .N(NUMN), .RST(1'b0)) u_num_dly (
                .aclk (aclk), .aresetn (aresetn), .en (en), .d_in (pr[i]), .d_out (pr_dly[i])
            );
            gau_div #(.NW(NUMW), .DW(DENW)) u_div (
                .aclk (aclk), .en (en),
                .num  ({pr_dly[i], {ACC_FRAC_BITS{1'b0}}}),
                .den  (den), .quo (quo[i])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_reg <= D2W'(sq[0]) + D2W'(sq[1]) + D2W'(sq[2]);
        end
    end

    gau_isqrt #(.VW(D2W)) u_isqrt (
        .aclk (aclk), .en (en), .v (d2_reg), .root (root)
    );

    gau_dly #(.W(D2W), .N(RW), .RST(1'b0)) u_d2_dly (
        .aclk (aclk), .aresetn (aresetn), .en (en), .d_in (d2_reg), .d_out (d2_dly)
    );

    gau_mul #(.WA(D2W), .WB(RW)) u_den (
        .aclk (aclk), .en (en), .a (d2_dly), .b (root), .p (den)
    );

    gau_dly #(.W(1), .N(SIDN), .RST(1'b1)) u_vld_dly (
        .aclk (aclk), .aresetn (aresetn), .en (en), .d_in (v1_reg), .d_out (v_end)
    );

    gau_dly #(.W(SIDW), .N(SIDN), .RST(1'b0)) u_side_dly (
        .aclk (aclk), .aresetn (aresetn), .en (en), .d_in (side_reg), .d_out (side_end)
    );

    // saturating accumulate
    always_comb begin
        sat = 1'b0;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            acc_in[i]   = side_end[5 + i*ACC_W +: ACC_W];
            acc_next[i] = acc_in[i];
        end
        if (!side_end[1]) begin
            status_next = ST_INSENSITIVE;
        end else if (side_end[0]) begin
            status_next = ST_ZERO_DIST;
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (quo[i][QUO_W-1]) begin
                    sat         = 1'b1;
                    acc_next[i] = side_end[2+i] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                : {1'b0, {(ACC_W-1){1'b1}}};
                end else if (!side_end[2+i]) begin
                    sum = acc_in[i] + quo[i];
                    if (!acc_in[i][ACC_W-1] && sum[ACC_W-1]) begin
                        sat         = 1'b1;
                        acc_next[i] = {1'b0, {(ACC_W-1){1'b1}}};
                    end else begin
                        acc_next[i] = sum;
                    end
                end else begin
                    sum = acc_in[i] - quo[i];
                    if (acc_in[i][ACC_W-1] && !sum[ACC_W-1]) begin
                        sat         = 1'b1;
                        acc_next[i] = {1'b1, {(ACC_W-1){1'b0}}};
                    end else begin
                        acc_next[i] = sum;
                    end
                end
            end
            status_next = sat ? ST_SATURATED : ST_APPLIED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg   <= {acc_next[2], acc_next[1], acc_next[0]};
            m_status_reg <= status_next;
        end
    end

endmodule

@@ sv/gau_dly.sv @@
// ----------------------------------------------------------------------------
// gau_dly
// Fixed-length delay line with enable, optionally cleared on reset.
// ----------------------------------------------------------------------------
module gau_dly #(
    parameter int W   = 1,
    parameter int N   = 1,
    parameter bit RST = 1'b0
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic [W-1:0] d_in,
    output logic [W-1:0] d_out
);

    logic [W-1:0] tap_reg [N];

    generate
        if (RST) begin : g_rst
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    for (int i = 0; i < N; i++) tap_reg[i] <= '0;
                end else if (en) begin
                    tap_reg[0] <= d_in;
                    for (int i = 1; i < N; i++) tap_reg[i] <= tap_reg[i-1];
                end
            end
        end else begin : g_norst
            always_ff @(posedge aclk) begin
                if (en) begin
                    tap_reg[0] <= d_in;
                    for (int i = 1; i < N; i++) tap_reg[i] <= tap_reg[i-1];
                end
            end
        end
    endgenerate

    assign d_out = tap_reg[N-1];

endmodule

@@ sv/gau_mul.sv @@
// ----------------------------------------------------------------------------
// gau_mul
// Unsigned multiplier, two stages: registered partial products, then sum.
// ----------------------------------------------------------------------------
module gau_mul
    import gau_pkg::*;
#(
    parameter int WA = 49,
    parameter int WB = 49
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [WA-1:0]   a,
    input  logic [WB-1:0]   b,
    output logic [WA+WB-1:0] p
);

    localparam int NA = (WA + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NB = (WB + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int SW = (NA + NB) * MUL_CHUNK;

    logic [NA*MUL_CHUNK-1:0]   ax;
    logic [NB*MUL_CHUNK-1:0]   bx;
    logic [2*MUL_CHUNK-1:0]    pp_reg [NA][NB];
    logic [SW-1:0]             sum;
    logic [WA+WB-1:0]          p_reg;

    assign ax = (NA*MUL_CHUNK)'(a);
    assign bx = (NB*MUL_CHUNK)'(b);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= (2*MUL_CHUNK)'(ax[i*MUL_CHUNK +: MUL_CHUNK])
                                  * (2*MUL_CHUNK)'(bx[j*MUL_CHUNK +: MUL_CHUNK]);
                end
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                sum = sum + (SW'(pp_reg[i][j]) << ((i + j) * MUL_CHUNK));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= sum[WA+WB-1:0];
        end
    end

    assign p = p_reg;

endmodule

@@ sv/gau_isqrt.sv @@
// ----------------------------------------------------------------------------
// gau_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module gau_isqrt #(
    parameter int VW = 100
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [VW-1:0]   v,
    output logic [VW/2-1:0] root
);

    localparam int RW = VW / 2;
    localparam int EW = RW + 3;

    logic [VW-1:0] val_reg  [RW];
    logic [EW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];

    generate
        for (genvar k = 0; k < RW; k++) begin : g_stage
            logic [VW-1:0] val_in;
            logic [EW-1:0] rem_in;
            logic [RW-1:0] root_in;
            logic [EW-1:0] rem_sh;
            logic [EW-1:0] trial;

            if (k == 0) begin : g_first
                assign val_in  = v;
                assign rem_in  = '0;
                assign root_in = '0;
            end else begin : g_next
                assign val_in  = val_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
            end

            assign rem_sh = {rem_in[EW-3:0], val_in[VW-1 -: 2]};
            assign trial  = {1'b0, root_in, 2'b01};

            always_ff @(posedge aclk) begin
                if (en) begin
                    val_reg[k] <= {val_in[VW-3:0], 2'b00};
                    if (rem_sh >= trial) begin
                        rem_reg[k]  <= rem_sh - trial;
                        root_reg[k] <= {root_in[RW-2:0], 1'b1};
                    end else begin
                        rem_reg[k]  <= rem_sh;
                        root_reg[k] <= {root_in[RW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[RW-1];

endmodule

@@ sv/gau_div.sv @@
// ----------------------------------------------------------------------------
// gau_div
// Pipelined restoring divider, one quotient bit per stage, top bit first.
// A set top quotient bit marks a quotient that does not fit below it.
// ----------------------------------------------------------------------------
module gau_div
    import gau_pkg::*;
#(
    parameter int NW = 145,
    parameter int DW = 150
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NW-1:0]    num,
    input  logic [DW-1:0]    den,
    output logic [QUO_W-1:0] quo
);

    localparam int EW = DW + QUO_W + 1;

    logic [NW-1:0]    rem_reg [QUO_W];
    logic [DW-1:0]    den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    generate
        for (genvar s = 0; s < QUO_W; s++) begin : g_stage
            localparam int K = QUO_W - 1 - s;
            logic [NW-1:0]    rem_in;
            logic [DW-1:0]    den_in;
            logic [QUO_W-1:0] quo_in;
            logic [EW-1:0]    rem_x;
            logic [EW-1:0]    den_x;
            logic [EW-1:0]    diff;

            if (s == 0) begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = rem_reg[s-1];
                assign den_in = den_reg[s-1];
                assign quo_in = quo_reg[s-1];
            end

            assign rem_x = EW'(rem_in);
            assign den_x = EW'(den_in) << K;
            assign diff  = rem_x - den_x;

            always_ff @(posedge aclk) begin
                if (en) begin
                    den_reg[s] <= den_in;
                    if (rem_x >= den_x) begin
                        rem_reg[s] <= diff[NW-1:0];
                        quo_reg[s] <= quo_in | (QUO_W'(1) << K);
                    end else begin
                        rem_reg[s] <= rem_in;
                        quo_reg[s] <= quo_in;
                    end
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QUO_W-1];

endmodule

@@ verif/gravity_acceleration_update_unit_test.sv @@
// ----------------------------------------------------------------------------
// gravity_acceleration_update_unit_test
// Self-checking bench for the gravity acceleration update unit. A table of
// directed body pairs (bypass, zero distance, saturation, coordinate
// extremes) is followed by random pairs under several gm settings. Every
// result is checked against its table entry or an exact integer model of the
// pull, with bursty input traffic and a stalling result side.
// ----------------------------------------------------------------------------
module gravity_acceleration_update_unit_test;
    import gau_pkg::*;

    localparam int POS_W     = 48;
    localparam int FRAC_W    = 48;
    localparam int TDATA_W   = ((6*POS_W+3*ACC_W+7)/8)*8;
    localparam int LATENCY   = POS_W + 73;
    localparam int CYCLE_CAP = 600000;

    localparam logic [63:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ACC_MIN = 64'h8000_0000_0000_0000;
    localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] POS_MIN = 48'h8000_0000_0000;

    typedef struct {
        logic [47:0] pos[6];
        logic        sens;
        logic [63:0] acc[3];
    } body_pair_t;

    typedef struct {
        logic [63:0] acc[3];
        status_t     st;
    } accel_t;

    typedef struct {
        body_pair_t pair;
        bit         typed;
        accel_t     res;
    } table_row_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [GM_W-1:0]    cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [3*ACC_W-1:0] m_tdata;
    logic [1:0]         m_tuser;

    logic [GM_W-1:0] gm_model;
    accel_t          pending_accel[$];
    int              errors;
    int              cycles;
    int              burst_left;
    table_row_t      dir_rows[$];

    gravity_acceleration_update_unit #(
        .POS_BITS      (POS_W),
        .ACC_FRAC_BITS (FRAC_W)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic accel_t predict_pull(body_pair_t p, logic [47:0] gm);
        longint            d[3];
        logic [63:0]       m[3];
        logic [255:0]      d2, den, num, q, sq;
        logic [63:0]       s, c;
        logic signed [65:0] sum, qs;
        bit                sat;
        accel_t            r;
        for (int i = 0; i < 3; i++) r.acc[i] = p.acc[i];
        if (!p.sens) begin
            r.st = ST_INSENSITIVE;
            return r;
        end
        d2 = '0;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'($signed(p.pos[i])) - longint'($signed(p.pos[3+i]));
            m[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
            d2 = d2 + {192'd0, m[i]} * {192'd0, m[i]};
        end
        if (d2 == 0) begin
            r.st = ST_ZERO_DIST;
            return r;
        end
        s = '0;
        for (int k = 63; k >= 0; k--) begin
            c = s | (64'd1 << k);
            sq = {192'd0, c} * {192'd0, c};
            if (sq <= d2) s = c;
        end
        den = d2 * {192'd0, s};
        sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            num = ({208'd0, gm} * {192'd0, m[i]}) << FRAC_W;
            q = num / den;
            if (q >= (256'd1 << 63)) begin
                sat = 1'b1;
                r.acc[i] = d[i] < 0 ? ACC_MIN : ACC_MAX;
            end else begin
                qs = $signed({2'b00, q[63:0]});
                sum = $signed({{2{p.acc[i][63]}}, p.acc[i]}) + (d[i] < 0 ? -qs : qs);
                if (sum > $signed({2'b00, ACC_MAX})) begin
                    sat = 1'b1;
                    r.acc[i] = ACC_MAX;
                end else if (sum < $signed({2'b11, ACC_MIN})) begin
                    sat = 1'b1;
                    r.acc[i] = ACC_MIN;
                end else begin
                    r.acc[i] = sum[63:0];
                end
            end
        end
        r.st = sat ? ST_SATURATED : ST_APPLIED;
        return r;
    endfunction

    function automatic table_row_t mk_row(logic [47:0] sx, logic [47:0] sy, logic [47:0] sz,
                                          logic [47:0] tx, logic [47:0] ty, logic [47:0] tz,
                                          logic sens, logic [63:0] ax, logic [63:0] ay,
                                          logic [63:0] az, bit typed, logic [63:0] ex,
                                          logic [63:0] ey, logic [63:0] ez, status_t est);
        table_row_t r;
        r.pair.pos[0] = sx; r.pair.pos[1] = sy; r.pair.pos[2] = sz;
        r.pair.pos[3] = tx; r.pair.pos[4] = ty; r.pair.pos[5] = tz;
        r.pair.sens = sens;
        r.pair.acc[0] = ax; r.pair.acc[1] = ay; r.pair.acc[2] = az;
        r.typed = typed;
        r.res.acc[0] = ex; r.res.acc[1] = ey; r.res.acc[2] = ez;
        r.res.st = est;
        return r;
    endfunction

    function automatic logic [47:0] rand_pos();
        case ($urandom_range(3))
            0: return {$urandom(), $urandom()};
            1: return 48'($signed($urandom_range(2000)) - 1000);
            2: return 48'($signed({$urandom()}) >>> $urandom_range(31));
            default: return $urandom_range(1) ? POS_MAX : POS_MIN;
        endcase
    endfunction

    function automatic logic [63:0] rand_acc();
        case ($urandom_range(4))
            0: return ACC_MAX - $urandom_range(3);
            1: return ACC_MIN + $urandom_range(3);
            2: return 64'($signed($urandom_range(65535)) - 32768);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic body_pair_t rand_pair();
        body_pair_t p;
        for (int i = 0; i < 3; i++) begin
            p.pos[i] = rand_pos();
            case ($urandom_range(9))
                0: p.pos[3+i] = p.pos[i];
                1, 2, 3: p.pos[3+i] = p.pos[i] + 48'($signed($urandom_range(200)) - 100);
                4, 5: p.pos[3+i] = p.pos[i] + 48'($signed({$urandom()}) >>> 8);
                default: p.pos[3+i] = rand_pos();
            endcase
            p.acc[i] = rand_acc();
        end
        if ($urandom_range(19) == 0)
            for (int i = 0; i < 3; i++) p.pos[3+i] = p.pos[i];
        p.sens = $urandom_range(7) != 0;
        return p;
    endfunction

    task automatic send_pair(body_pair_t p, bit typed, accel_t res);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
            burst_left = $urandom_range(3) == 0 ? $urandom_range(80, 40) : $urandom_range(20, 1);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= p.sens;
        s_tdata  <= {p.acc[2], p.acc[1], p.acc[0], p.pos[5], p.pos[4], p.pos[3],
                     p.pos[2], p.pos[1], p.pos[0]};
        do @(posedge aclk); while (!s_tready);
        pending_accel.push_back(typed ? res : predict_pull(p, gm_model));
    endtask

    task automatic drain_and_wait();
        s_tvalid <= 1'b0;
        while (pending_accel.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic write_gm(logic [47:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        gm_model  = v;
    endtask

    // result side: stall pattern and checking
    int stall_mode;
    always @(posedge aclk) begin
        accel_t e;
        cycles <= cycles + 1;
        if (cycles % 97 == 0) stall_mode <= $urandom_range(3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(1);
            2: m_tready <= $urandom_range(7) == 0;
            default: m_tready <= (cycles % 13) < 9;
        endcase
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_accel.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
            end else begin
                e = pending_accel.pop_front();
                for (int i = 0; i < 3; i++)
                    if (m_tdata[64*i +: 64] !== e.acc[i]) begin
                        $error("acc_%0d_out expected %h actual %h", i, e.acc[i],
                               m_tdata[64*i +: 64]);
                        errors++;
                    end
                if (m_tuser !== e.st) begin
                    $error("status expected %0d actual %0d", e.st, m_tuser);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_CAP) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [47:0] gm_set[5];
        accel_t      none;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        stall_mode = 0;
        errors     = 0;
        cycles     = 0;
        burst_left = 0;
        gm_model   = GM_RESET;
        none.acc[0] = '0; none.acc[1] = '0; none.acc[2] = '0;
        none.st = ST_APPLIED;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // insensitive target, also at zero distance
        dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, ACC_MAX, ACC_MIN, 0,
                                  1, ACC_MAX, ACC_MIN, 0, ST_INSENSITIVE));
        dir_rows.push_back(mk_row(POS_MAX, 5, POS_MIN, 1, 2, 3, 0, 1, 2, 3,
                                  1, 1, 2, 3, ST_INSENSITIVE));
        // zero distance
        dir_rows.push_back(mk_row(POS_MAX, POS_MIN, 7, POS_MAX, POS_MIN, 7, 1, 9, ACC_MIN,
                                  ACC_MAX, 1, 9, ACC_MIN, ACC_MAX, ST_ZERO_DIST));
        // one kilometre apart: the pull itself overflows
        dir_rows.push_back(mk_row(1, 0, 0, 0, 0, 0, 1, 0, 4, 5,
                                  1, ACC_MAX, 4, 5, ST_SATURATED));
        dir_rows.push_back(mk_row(0, 0, -1, 0, 0, 0, 1, 4, 5, 0,
                                  1, 4, 5, ACC_MIN, ST_SATURATED));
        // sum overflow in either direction
        dir_rows.push_back(mk_row(1000000, 0, 0, 0, 0, 0, 1, ACC_MAX, 0, 0,
                                  1, ACC_MAX, 0, 0, ST_SATURATED));
        dir_rows.push_back(mk_row(0, -1000000, 0, 0, 0, 0, 1, 0, ACC_MIN, 0,
                                  1, 0, ACC_MIN, 0, ST_SATURATED));
        // coordinate extremes and ordinary orbits
        dir_rows.push_back(mk_row(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN, 1,
                                  0, ACC_MIN, ACC_MAX, 0, 0, 0, 0, ST_APPLIED));
        dir_rows.push_back(mk_row(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX, 1,
                                  ACC_MAX, 0, ACC_MIN, 0, 0, 0, 0, ST_APPLIED));
        dir_rows.push_back(mk_row(0, 0, 0, 149597870, 0, 0, 1, 0, 0, 0,
                                  0, 0, 0, 0, ST_APPLIED));
        dir_rows.push_back(mk_row(-4000, 3000, 12000, 1000, -7000, 5000, 1,
                                  -64'sd5, 64'sd77, 0, 0, 0, 0, 0, ST_APPLIED));
        dir_rows.push_back(mk_row(POS_MAX, 0, POS_MIN, 0, POS_MAX, 0, 1,
                                  ACC_MAX - 1, ACC_MIN + 1, 1, 0, 0, 0, 0, ST_APPLIED));
        foreach (dir_rows[n]) send_pair(dir_rows[n].pair, dir_rows[n].typed, dir_rows[n].res);
        drain_and_wait();

        gm_set[0] = 48'hFFFF_FFFF_FFFF;
        gm_set[1] = 48'd0;
        gm_set[2] = 48'd1;
        gm_set[3] = {$urandom(), $urandom()};
        gm_set[4] = GM_RESET;
        for (int ph = 0; ph < 5; ph++) begin
            write_gm(gm_set[ph]);
            for (int n = 0; n < 330; n++) send_pair(rand_pair(), 1'b0, none);
            drain_and_wait();
        end

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
